// ===== rtl/fulp_pkg.sv =====
// Shared constants and types for the float ULP near-compare block.
`timescale 1ns / 1ps
`default_nettype none
package fulp_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned DIST_W = 31;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_FIXED_EPSILON = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ULP_LIMIT = 8'd1;

    localparam logic [WORD_W-1:0] EPSILON_RESET = 32'h3400_0000;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 31'd10;
    localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] INF_MAG = 31'h7F80_0000;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DIST_W-1:0] dist_t;
endpackage
`default_nettype wire

// ===== rtl/fulp_ifs.sv =====
// Handshake interfaces for operands, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface fulp_operand_if;
    logic               valid;
    logic               ready;
    fulp_pkg::word_t    first_value;
    fulp_pkg::word_t    second_value;
    modport source (output valid, output first_value, output second_value, input ready);
    modport sink (input valid, input first_value, input second_value, output ready);
endinterface

interface fulp_result_if;
    logic               valid;
    logic               ready;
    logic               is_near;
    fulp_pkg::dist_t    ulp_distance;
    modport source (output valid, output is_near, output ulp_distance, input ready);
    modport sink (input valid, input is_near, input ulp_distance, output ready);
endinterface

interface fulp_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [fulp_pkg::CFG_INDEX_W-1:0]       index;
    fulp_pkg::word_t                        data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/fulp_ulp_dist.sv =====
// ULP distance between two single-precision bit patterns.
`timescale 1ns / 1ps
`default_nettype none
module fulp_ulp_dist
(
    input  wire fulp_pkg::word_t a,
    input  wire fulp_pkg::word_t b,
    output fulp_pkg::dist_t      distance
);
    import fulp_pkg::*;

    logic  a_nan;
    logic  b_nan;
    logic  a_inf;
    logic  b_inf;
    logic  equal;
    word_t diff;

    assign a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    assign a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    // +0 and -0 compare equal
    assign equal = !a_nan && !b_nan && (((a[30:0] | b[30:0]) == 31'd0) || (a == b));
    assign diff  = (a >= b) ? (a - b) : (b - a);

    // pick the distance by class
    always_comb
    begin
        if (equal)
            distance = '0;
        else if (a_nan || b_nan || a_inf || b_inf || (a[31] != b[31]))
            distance = DIST_MAX;
        else
            distance = diff[DIST_W-1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/fulp_eps_check.sv =====
// Rounded single-precision |a-b| compared against a tolerance pattern.
`timescale 1ns / 1ps
`default_nettype none
module fulp_eps_check
(
    input  wire fulp_pkg::word_t a,
    input  wire fulp_pkg::word_t b,
    input  wire fulp_pkg::word_t eps,
    output logic                 pass
);
    import fulp_pkg::*;

    logic        a_nan, b_nan, a_inf, b_inf, eps_nan;
    logic        eff_sub, diff_nan, diff_inf;
    logic [30:0] x_mag, y_mag, diff_mag, rnd;
    logic [7:0]  ex, ey, dsh, max_sh;
    logic [23:0] mx, my;
    logic [26:0] y_wide, y_shift, y_al, x_al, norm;
    logic        y_sticky, round_up;
    logic [27:0] sum;
    logic [4:0]  lz, sh;
    logic [8:0]  expf;

    // count leading zeros of a 27-bit word
    function automatic logic [4:0] lead_zeros(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    assign a_nan   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    assign a_inf   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    assign eps_nan = (eps[30:23] == 8'hFF) && (eps[22:0] != 23'd0);
    // a - b subtracts magnitudes when the signs agree
    assign eff_sub  = (a[31] == b[31]);
    assign diff_nan = a_nan || b_nan || (a_inf && b_inf && eff_sub);
    assign diff_inf = a_inf || b_inf;

    // order operands by magnitude
    assign x_mag = (a[30:0] >= b[30:0]) ? a[30:0] : b[30:0];
    assign y_mag = (a[30:0] >= b[30:0]) ? b[30:0] : a[30:0];
    assign ex    = (x_mag[30:23] == 8'd0) ? 8'd1 : x_mag[30:23];
    assign ey    = (y_mag[30:23] == 8'd0) ? 8'd1 : y_mag[30:23];
    assign mx    = {x_mag[30:23] != 8'd0, x_mag[22:0]};
    assign my    = {y_mag[30:23] != 8'd0, y_mag[22:0]};
    assign dsh   = ex - ey;

    // align the smaller operand, keep a sticky bit
    assign y_wide = {my, 3'b000};
    always_comb
    begin
        if (dsh >= 8'd27)
        begin
            y_shift  = '0;
            y_sticky = |my;
        end
        else
        begin
            y_shift  = y_wide >> dsh[4:0];
            y_sticky = |(y_wide & ~({27{1'b1}} << dsh[4:0]));
        end
    end
    assign y_al = {y_shift[26:1], y_shift[0] | y_sticky};
    assign x_al = {mx, 3'b000};
    assign sum  = eff_sub ? ({1'b0, x_al} - {1'b0, y_al}) : ({1'b0, x_al} + {1'b0, y_al});

    // normalize, stopping at the subnormal range
    assign lz     = lead_zeros(sum[26:0]);
    assign max_sh = ex - 8'd1;
    assign sh     = ({3'b000, lz} > max_sh) ? max_sh[4:0] : lz;
    always_comb
    begin
        if (sum[27])
        begin
            norm = {sum[27:2], sum[1] | sum[0]};
            expf = {1'b0, ex} + 9'd1;
        end
        else
        begin
            norm = sum[26:0] << sh;
            expf = norm[26] ? ({1'b0, ex} - {4'b0000, sh}) : 9'd0;
        end
    end

    // round to nearest even; a mantissa carry ripples into the exponent
    assign round_up = norm[2] && (norm[1] || norm[0] || norm[3]);
    assign rnd      = {expf[7:0], norm[25:3]} + {30'd0, round_up};
    assign diff_mag = (diff_inf || expf >= 9'd255) ? INF_MAG : rnd;

    // tolerance compare; -0 acts as +0
    always_comb
    begin
        if (diff_nan || eps_nan)
            pass = 1'b0;
        else if (eps[31])
            pass = (eps[30:0] == 31'd0) && (diff_mag == 31'd0);
        else
            pass = (diff_mag <= eps[30:0]);
    end
endmodule
`default_nettype wire

// ===== rtl/float_ulp_near_compare_unit.sv =====
// Top level of the float ULP near-compare block.
`timescale 1ns / 1ps
`default_nettype none
// Compares two IEEE-754 single-precision bit patterns and returns their ULP
// distance and a near flag (rounded |a-b| within fixed_epsilon, or distance
// within the ULP limit). One pair is accepted per cycle while the result
// register is free or being taken; the operands pass through the operand
// register while the subtract/compare logic feeds the result register,
// which drives results.valid. Registers (index 0 fixed_epsilon, index 1 ULP
// limit) are written through cfg, which is always ready; write them only
// while the block is idle.
module float_ulp_near_compare_unit
(
    input  wire          clk,
    input  wire          rst_n,
    fulp_cfg_if.sink     cfg,
    fulp_operand_if.sink operands,
    fulp_result_if.source results
);
    import fulp_pkg::*;

    word_t fixed_epsilon_reg;
    dist_t ulp_limit_reg;
    logic  op_valid_reg;
    word_t op_a_reg;
    word_t op_b_reg;
    logic  res_valid_reg;
    logic  res_near_reg;
    dist_t res_dist_reg;
    logic  res_free;
    logic  op_advance;
    logic  eps_pass;
    dist_t distance;

    assign cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_epsilon_reg <= EPSILON_RESET;
            ulp_limit_reg     <= THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FIXED_EPSILON: fixed_epsilon_reg <= cfg.data;
                REG_ULP_LIMIT:     ulp_limit_reg <= cfg.data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the pipeline whenever the result slot frees up
    assign res_free       = !res_valid_reg || results.ready;
    assign op_advance     = res_free;
    assign operands.ready = !op_valid_reg || op_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_valid_reg <= 1'b0;
        else if (operands.ready)
            op_valid_reg <= operands.valid;
    end

    always_ff @(posedge clk)
    begin
        if (operands.ready && operands.valid)
        begin
            op_a_reg <= operands.first_value;
            op_b_reg <= operands.second_value;
        end
    end

    fulp_ulp_dist u_dist
    (
        .a        (op_a_reg),
        .b        (op_b_reg),
        .distance (distance)
    );

    fulp_eps_check u_eps
    (
        .a    (op_a_reg),
        .b    (op_b_reg),
        .eps  (fixed_epsilon_reg),
        .pass (eps_pass)
    );

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= op_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (res_free && op_valid_reg)
        begin
            res_near_reg <= eps_pass || (distance <= ulp_limit_reg);
            res_dist_reg <= distance;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.is_near      = res_near_reg;
    assign results.ulp_distance = res_dist_reg;
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for float_ulp_near_compare_unit: directed, random, register sweep and backpressure checks.
`timescale 1ns / 1ps
module tb;
    import fulp_pkg::*;

    typedef struct packed {
        logic  is_near;
        dist_t ulp_distance;
    } compare_result_t;

    logic clk;
    logic rst_n;

    fulp_cfg_if     cfg_if();
    fulp_operand_if op_if();
    fulp_result_if  res_if();

    float_ulp_near_compare_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_if),
        .operands (op_if),
        .results  (res_if)
    );

    // Local copy of the register file
    word_t tol_bits;
    dist_t ulp_limit;

    compare_result_t pending_results[$];
    int unsigned     mismatch_count;
    bit              idle_enable;
    bit              hold_results;
    int unsigned     result_stall;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Magnitude of a finite operand in units of the smallest subnormal
    function automatic logic [299:0] to_units(word_t x);
        logic [299:0] sig;
        sig = 300'({(x[30:23] != 8'd0), x[22:0]});
        if (x[30:23] != 8'd0)
        begin
            sig = sig << (x[30:23] - 1);
        end
        return sig;
    endfunction

    function automatic bit is_nan(word_t x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(word_t x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    // Round an exact magnitude to single precision, nearest even
    function automatic word_t round_units(logic [299:0] mag);
        int          lead;
        int          sh;
        int          expo;
        logic [24:0] kept;
        logic [299:0] low_mask;
        bit          guard;
        bit          sticky;
        lead = -1;
        for (int i = 0; i < 300; i++)
        begin
            if (mag[i])
            begin
                lead = i;
            end
        end
        if (lead <= 23)
        begin
            return word_t'(mag[31:0]);
        end
        sh = lead - 23;
        kept = 25'(mag >> sh);
        guard = mag[sh-1];
        low_mask = (300'd1 << (sh - 1)) - 300'd1;
        sticky = |(mag & low_mask);
        expo = lead - 22;
        if (guard && (sticky || kept[0]))
        begin
            kept = kept + 25'd1;
        end
        if (kept[24])
        begin
            kept = kept >> 1;
            expo = expo + 1;
        end
        if (expo >= 255)
        begin
            return {1'b0, INF_MAG};
        end
        return {1'b0, expo[7:0], kept[22:0]};
    endfunction

    // Tolerance test on the rounded |a-b|
    function automatic bit within_tolerance(word_t a, word_t b);
        word_t        diff_mag;
        logic [299:0] ua;
        logic [299:0] ub;
        if (is_nan(a) || is_nan(b) || is_nan(tol_bits))
        begin
            return 1'b0;
        end
        if (is_inf(a) || is_inf(b))
        begin
            // inf - inf of the same sign gives NaN
            if (is_inf(a) && is_inf(b) && (a[31] == b[31]))
            begin
                return 1'b0;
            end
            diff_mag = {1'b0, INF_MAG};
        end
        else
        begin
            ua = to_units(a);
            ub = to_units(b);
            if (a[31] != b[31])
            begin
                diff_mag = round_units(ua + ub);
            end
            else
            begin
                diff_mag = round_units((ua > ub) ? ua - ub : ub - ua);
            end
        end
        if (tol_bits[31])
        begin
            return (tol_bits[30:0] == 31'd0) && (diff_mag == 32'd0);
        end
        return diff_mag <= tol_bits;
    endfunction

    function automatic compare_result_t predict_compare(word_t a, word_t b);
        compare_result_t r;
        word_t           gap;
        if (!is_nan(a) && !is_nan(b) && ((((a | b) & 32'h7FFF_FFFF) == 32'd0) || a == b))
        begin
            r.ulp_distance = '0;
        end
        else if (is_nan(a) || is_nan(b) || is_inf(a) || is_inf(b) || (a[31] != b[31]))
        begin
            r.ulp_distance = DIST_MAX;
        end
        else
        begin
            gap = (a >= b) ? a - b : b - a;
            r.ulp_distance = gap[30:0];
        end
        r.is_near = within_tolerance(a, b) || (r.ulp_distance <= ulp_limit);
        return r;
    endfunction

    // Check each accepted result and draw the next receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        compare_result_t got;
        compare_result_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            result_stall = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.is_near = res_if.is_near;
                got.ulp_distance = res_if.ulp_distance;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result near=%0b dist=%0d", $time,
                             got.is_near, got.ulp_distance);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.is_near !== want.is_near)
                    begin
                        mismatch_count++;
                        $display("%0t: is_near expected %0b actual %0b", $time,
                                 want.is_near, got.is_near);
                    end
                    if (got.ulp_distance !== want.ulp_distance)
                    begin
                        mismatch_count++;
                        $display("%0t: ulp_distance expected %0d actual %0d", $time,
                                 want.ulp_distance, got.ulp_distance);
                    end
                end
                result_stall = idle_enable ? $urandom_range(0, 5) : 0;
            end
            if (hold_results)
            begin
                res_if.ready <= 1'b0;
            end
            else if (result_stall > 0)
            begin
                result_stall--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Offer one operand pair; keep valid high when the next item follows at once
    task automatic send_pair(word_t a, word_t b);
        int unsigned gap;
        gap = idle_enable ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_if.valid <= 1'b1;
        op_if.first_value <= a;
        op_if.second_value <= b;
        do
        begin
            @(posedge clk);
        end
        while (!op_if.ready);
        pending_results.push_back(predict_compare(a, b));
    endtask

    task automatic drop_valid();
        op_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every result, then let the pipeline settle
    task automatic drain();
        drop_valid();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, word_t data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == REG_FIXED_EPSILON)
        begin
            tol_bits = data;
        end
        else
        begin
            ulp_limit = data[DIST_W-1:0];
        end
        @(posedge clk);
    endtask

    // Draw operands biased toward special values
    function automatic word_t random_word();
        word_t w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[30:0] = 31'd0;
            1: w[30:0] = INF_MAG;
            2: w[30:23] = 8'hFF;
            3: w[30:23] = 8'h00;
            4: w[30:23] = 8'hFE;
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_random_pairs(int unsigned count);
        word_t a;
        word_t b;
        int    step;
        for (int unsigned n = 0; n < count; n++)
        begin
            a = random_word();
            case ($urandom_range(0, 3))
                0: b = random_word();
                1:
                begin
                    // neighbor within a few ulps, same sign
                    step = $urandom_range(0, 24) - 12;
                    b = a + word_t'(step);
                    b[31] = a[31];
                end
                2:
                begin
                    b = a;
                    b[22:0] = 23'($urandom);
                end
                default:
                begin
                    b = a ^ (32'd1 << $urandom_range(0, 31));
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                send_pair(a, b);
            end
            else
            begin
                send_pair(b, a);
            end
        end
    endtask

    task automatic test_directed();
        word_t cases[22][2];
        cases = '{
            '{32'h0000_0000, 32'h8000_0000}, '{32'h7FC0_0000, 32'h7FC0_0000},
            '{32'h7F80_0000, 32'h7F80_0000}, '{32'h7F80_0000, 32'hFF80_0000},
            '{32'h7F80_0000, 32'h7F7F_FFFF}, '{32'h3F80_0000, 32'hBF80_0000},
            '{32'h3F80_0000, 32'h3F80_0001}, '{32'h3F80_0000, 32'h3F80_000A},
            '{32'h3F80_0000, 32'h3F80_000B}, '{32'h0000_0001, 32'h8000_0001},
            '{32'h0000_0001, 32'h007F_FFFF}, '{32'h0080_0000, 32'h007F_FFFF},
            '{32'h7F7F_FFFF, 32'hFF7F_FFFF}, '{32'h7F7F_FFFF, 32'h7F7F_FFFE},
            '{32'hFFFF_FFFF, 32'h0000_0000}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{32'h7F80_0001, 32'h3F80_0000}, '{32'h0000_0000, 32'h7FFF_FFFF},
            '{32'h3400_0000, 32'h0000_0000}, '{32'h4B80_0000, 32'h4B80_0001},
            '{32'hCB80_0000, 32'hCB80_0010}, '{32'h8000_0000, 32'h0000_0005}
        };
        foreach (cases[i])
        begin
            send_pair(cases[i][0], cases[i][1]);
        end
        drain();
    endtask

    task automatic test_random_default();
        send_random_pairs(500);
        drain();
    endtask

    // Step through register extremes and odd tolerance encodings
    task automatic test_register_sweep();
        word_t       eps_set[7];
        dist_t       thr_set[4];
        eps_set = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0001, 32'hBF80_0000,
                    32'h7F80_0000, 32'hFFFF_FFFF, 32'h0000_0001};
        thr_set = '{31'd0, DIST_MAX, 31'd1, 31'h00FF_FFFF};
        for (int i = 0; i < 7; i++)
        begin
            write_reg(REG_FIXED_EPSILON, eps_set[i]);
            write_reg(REG_ULP_LIMIT, {1'b0, thr_set[i % 4]});
            send_pair(32'h7FC0_0000, 32'h3F80_0000);
            send_pair(32'h0000_0000, 32'h8000_0000);
            send_random_pairs(80);
            drain();
        end
        write_reg(REG_FIXED_EPSILON, $urandom);
        write_reg(REG_ULP_LIMIT, $urandom);
        send_random_pairs(100);
        drain();
        write_reg(REG_FIXED_EPSILON, EPSILON_RESET);
        write_reg(REG_ULP_LIMIT, {1'b0, THRESHOLD_RESET});
    endtask

    // Stall the receiver long enough to back up the input
    task automatic test_backpressure();
        idle_enable = 1'b0;
        fork
            begin
                hold_results = 1'b1;
                repeat (60) @(posedge clk);
                hold_results = 1'b0;
            end
            send_random_pairs(80);
        join
        send_random_pairs(60);
        idle_enable = 1'b1;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        mismatch_count = 0;
        idle_enable = 1'b1;
        hold_results = 1'b0;
        tol_bits = EPSILON_RESET;
        ulp_limit = THRESHOLD_RESET;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        op_if.valid = 1'b0;
        op_if.first_value = '0;
        op_if.second_value = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_default();
        test_register_sweep();
        test_backpressure();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop on a hung handshake
    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
